// ===== sv/volume_trilinear_sampler_unit_assert.svh =====
// assertion macros for the volume sampler
// used by the top level only; needs nothing else
`ifndef VOLUME_TRILINEAR_SAMPLER_UNIT_ASSERT_SVH
`define VOLUME_TRILINEAR_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define VTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define VTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vts_pkg.sv =====
// shared types, constants and coordinate helpers for the volume sampler
// no dependencies; imported by every module of the block
package vts_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int COORD_BITS  = 20;
  localparam int OUT_BITS    = 24;

  localparam int IDX_W       = $clog2(MAX_SIDE);
  localparam int ADDR_W      = 3 * IDX_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int EXT_W       = IDX_W + 1;
  localparam int BASE_W      = COORD_BITS - FRAC_BITS + 2;
  localparam int WGT_W       = FRAC_BITS + 1;
  localparam int WXY_W       = 2 * FRAC_BITS + 1;
  localparam int W_W         = 3 * FRAC_BITS + 1;
  localparam int ACC_W       = SAMPLE_BITS + W_W + 2;

  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_W   = PADDR_W - 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_LINEAR = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ZB     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_THREE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_EXT_X  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_EXT_Y  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_EXT_Z  = 3'd5;

  // item opcode
  localparam logic OP_SAMPLE = 1'b1;

  // final shift codes
  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_ONE  = 2'd1;
  localparam logic [1:0] SH_TWO  = 2'd2;

  // last neighbour index per mode
  localparam logic [2:0] NB_ONE   = 3'd0;
  localparam logic [2:0] NB_FOUR  = 3'd3;
  localparam logic [2:0] NB_EIGHT = 3'd7;

  localparam logic [WGT_W-1:0] UNIT_WGT = WGT_W'(1);
  localparam logic [WGT_W-1:0] ONE_WGT  = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic             lin;
    logic             zb;
    logic             three;
    logic [EXT_W-1:0] ext_x;
    logic [EXT_W-1:0] ext_y;
    logic [EXT_W-1:0] ext_z;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             zero;
  } axis_pos_t;

  // one queued item, already classified
  typedef struct packed {
    logic                         is_sample;
    logic [ADDR_W-1:0]            addr;
    logic [SAMPLE_BITS-1:0]       data;
    axis_pos_t [1:0]              px;
    axis_pos_t [1:0]              py;
    axis_pos_t [1:0]              pz;
    logic [1:0][WGT_W-1:0]        wx;
    logic [1:0][WGT_W-1:0]        wy;
    logic [1:0][WGT_W-1:0]        wz;
    logic [2:0]                   last;
    logic [1:0]                   sh;
  } qent_t;

  typedef struct packed {
    logic busy;
    logic fin;
  } bk_stat_t;

  // extent of 0 acts as 1, above the side acts as the side
  function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] e);
    logic [EXT_W-1:0] r;
    if (e == '0) r = EXT_W'(1);
    else if (e > EXT_W'(MAX_SIDE)) r = EXT_W'(MAX_SIDE);
    else r = e;
    return r;
  endfunction

  function automatic logic signed [BASE_W-1:0] floor_coord(
    input logic signed [COORD_BITS-1:0] c);
    return BASE_W'(c >>> FRAC_BITS);
  endfunction

  // round half away from zero
  function automatic logic signed [BASE_W-1:0] round_coord(
    input logic signed [COORD_BITS-1:0] c);
    logic             neg;
    logic [COORD_BITS:0] m;
    logic [COORD_BITS:0] r;
    logic [BASE_W-1:0]   rb;
    neg = c[COORD_BITS-1];
    m = neg ? (~{c[COORD_BITS-1], c} + 1'b1) : {1'b0, c};
    r = (m + ((COORD_BITS + 1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    rb = r[BASE_W-1:0];
    return neg ? BASE_W'(-$signed(rb)) : $signed(rb);
  endfunction

  // clamp to edge or flag as zero border
  function automatic axis_pos_t fix_pos(input logic signed [BASE_W-1:0] i,
                                        input logic [EXT_W-1:0] ext,
                                        input logic zb);
    axis_pos_t p;
    logic      lo;
    logic      hi;
    lo = (i < 0);
    hi = !lo && (i >= $signed({{(BASE_W - EXT_W){1'b0}}, ext}));
    p.zero = (lo || hi) && zb;
    if (lo) p.idx = '0;
    else if (hi) p.idx = IDX_W'(ext - EXT_W'(1));
    else p.idx = i[IDX_W-1:0];
    return p;
  endfunction

endpackage

// ===== sv/volume_trilinear_sampler_unit.sv =====
// top level of the volume sampler: register port, front end, back end, checks
// depends on vts_pkg, vts_front, vts_back and the assertion macro header
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    op, cell_address, cell_value, coord_x/y/z
//   out      output     out_valid / out_ready  sampled_value
//   cfg      input      psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// a write item uses the single memory port in the back end and waits while sample reads issue
// a sample is dispatched, then makes 1, 4 or 8 memory reads (nearest, 2D, 3D), one per
// cycle, then passes through weight multiply, sample multiply, accumulate and rounding
// until the result register loads
// a new sample waits for the pipeline to drain and the result register to be free;
// a two-entry queue keeps taking items while the back end works or a result waits
// synchronous active-low reset clears control state; the grid holds garbage until written
`include "volume_trilinear_sampler_unit_assert.svh"

module volume_trilinear_sampler_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_op,
  input  logic [vts_pkg::ADDR_W-1:0]             in_cell_address,
  input  logic signed [vts_pkg::SAMPLE_BITS-1:0] in_cell_value,
  input  logic signed [vts_pkg::COORD_BITS-1:0]  in_coord_x,
  input  logic signed [vts_pkg::COORD_BITS-1:0]  in_coord_y,
  input  logic signed [vts_pkg::COORD_BITS-1:0]  in_coord_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [vts_pkg::OUT_BITS-1:0]    out_sampled_value,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [vts_pkg::PADDR_W-1:0]            paddr,
  input  logic [vts_pkg::PDATA_W-1:0]            pwdata,
  output logic [vts_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready
);
  import vts_pkg::*;

  logic               lin_r;
  logic               zb_r;
  logic               three_r;
  logic [EXT_W-1:0]   ext_x_r;
  logic [EXT_W-1:0]   ext_y_r;
  logic [EXT_W-1:0]   ext_z_r;
  logic               cfg_we;
  logic [REG_IDX_W-1:0] reg_idx;
  cfg_t               cfg;

  logic               q_valid;
  logic               q_pop;
  qent_t              q_head;
  logic [Q_CNT_W-1:0] q_count;
  bk_stat_t           bk_stat;

  // register port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_r   <= 1'b1;
      zb_r    <= 1'b0;
      three_r <= 1'b1;
      ext_x_r <= EXT_W'(MAX_SIDE);
      ext_y_r <= EXT_W'(MAX_SIDE);
      ext_z_r <= EXT_W'(MAX_SIDE);
    end else if (cfg_we) begin
      case (reg_idx)
        REG_LINEAR: lin_r   <= pwdata[0];
        REG_ZB:     zb_r    <= pwdata[0];
        REG_THREE:  three_r <= pwdata[0];
        REG_EXT_X:  ext_x_r <= pwdata[EXT_W-1:0];
        REG_EXT_Y:  ext_y_r <= pwdata[EXT_W-1:0];
        REG_EXT_Z:  ext_z_r <= pwdata[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_LINEAR: prdata = PDATA_W'(lin_r);
      REG_ZB:     prdata = PDATA_W'(zb_r);
      REG_THREE:  prdata = PDATA_W'(three_r);
      REG_EXT_X:  prdata = PDATA_W'(ext_x_r);
      REG_EXT_Y:  prdata = PDATA_W'(ext_y_r);
      REG_EXT_Z:  prdata = PDATA_W'(ext_z_r);
      default:    prdata = '0;
    endcase
  end

  // effective settings
  always_comb begin
    cfg.lin   = lin_r;
    cfg.zb    = zb_r;
    cfg.three = three_r;
    cfg.ext_x = eff_extent(ext_x_r);
    cfg.ext_y = eff_extent(ext_y_r);
    cfg.ext_z = eff_extent(ext_z_r);
  end

  vts_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_cell_address (in_cell_address),
    .in_cell_value   (in_cell_value),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_head          (q_head),
    .q_count         (q_count)
  );

  vts_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sampled_value (out_sampled_value),
    .stat              (bk_stat)
  );

  // checks
  `VTS_ASSERT_IMPL(a_no_out_while_busy, clk, rst_n, bk_stat.busy, !out_valid, "result while busy")
  `VTS_ASSERT_NEXT(a_accept_queued, clk, rst_n, in_valid && in_ready, q_count != '0, "item not queued")
  `VTS_ASSERT_IMPL(a_out_after_fin, clk, rst_n, $rose(out_valid), $past(bk_stat.fin), "stray result")

endmodule

// ===== sv/vts_front.sv =====
// front end: takes items, works out neighbour indices and weights, queues them
// depends on vts_pkg
module vts_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  vts_pkg::cfg_t                          cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_op,
  input  logic [vts_pkg::ADDR_W-1:0]             in_cell_address,
  input  logic signed [vts_pkg::SAMPLE_BITS-1:0] in_cell_value,
  input  logic signed [vts_pkg::COORD_BITS-1:0]  in_coord_x,
  input  logic signed [vts_pkg::COORD_BITS-1:0]  in_coord_y,
  input  logic signed [vts_pkg::COORD_BITS-1:0]  in_coord_z,
  output logic                                   q_valid,
  input  logic                                   q_pop,
  output vts_pkg::qent_t                         q_head,
  output logic [vts_pkg::Q_CNT_W-1:0]            q_count
);
  import vts_pkg::*;

  logic signed [COORD_BITS-1:0] cz;
  logic signed [BASE_W-1:0]     bx;
  logic signed [BASE_W-1:0]     by;
  logic signed [BASE_W-1:0]     bz;
  qent_t                        ent;

  qent_t              q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] q_wp_r;
  logic [Q_PTR_W-1:0] q_rp_r;
  logic [Q_CNT_W-1:0] q_cnt_r;
  logic               push;
  logic               pop;

  // classify the incoming item
  always_comb begin
    cz = cfg.three ? in_coord_z : '0;
    bx = cfg.lin ? floor_coord(in_coord_x) : round_coord(in_coord_x);
    by = cfg.lin ? floor_coord(in_coord_y) : round_coord(in_coord_y);
    bz = cfg.lin ? floor_coord(cz) : round_coord(cz);

    ent.is_sample = (in_op == OP_SAMPLE);
    ent.addr      = in_cell_address;
    ent.data      = in_cell_value;
    ent.px[0]     = fix_pos(bx, cfg.ext_x, cfg.zb);
    ent.px[1]     = fix_pos(BASE_W'(bx + 1), cfg.ext_x, cfg.zb);
    ent.py[0]     = fix_pos(by, cfg.ext_y, cfg.zb);
    ent.py[1]     = fix_pos(BASE_W'(by + 1), cfg.ext_y, cfg.zb);
    ent.pz[0]     = fix_pos(bz, cfg.ext_z, cfg.zb);
    ent.pz[1]     = fix_pos(BASE_W'(bz + 1), cfg.ext_z, cfg.zb);

    // nearest: one cell scaled to fixed point
    ent.wx[0] = UNIT_WGT;
    ent.wx[1] = '0;
    ent.wy[0] = UNIT_WGT;
    ent.wy[1] = '0;
    ent.wz[0] = ONE_WGT;
    ent.wz[1] = '0;
    ent.last  = NB_ONE;
    ent.sh    = SH_NONE;
    if (cfg.lin) begin
      ent.wx[1] = WGT_W'(in_coord_x[FRAC_BITS-1:0]);
      ent.wx[0] = ONE_WGT - WGT_W'(in_coord_x[FRAC_BITS-1:0]);
      ent.wy[1] = WGT_W'(in_coord_y[FRAC_BITS-1:0]);
      ent.wy[0] = ONE_WGT - WGT_W'(in_coord_y[FRAC_BITS-1:0]);
      if (cfg.three) begin
        ent.wz[1] = WGT_W'(cz[FRAC_BITS-1:0]);
        ent.wz[0] = ONE_WGT - WGT_W'(cz[FRAC_BITS-1:0]);
        ent.last  = NB_EIGHT;
        ent.sh    = SH_TWO;
      end else begin
        ent.wz[0] = UNIT_WGT;
        ent.last  = NB_FOUR;
        ent.sh    = SH_ONE;
      end
    end
  end

  // queue handshake
  assign in_ready = (q_cnt_r != Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (q_cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_head   = q_r[q_rp_r];
  assign q_count  = q_cnt_r;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[q_wp_r] <= ent;
    end
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (push) begin
        q_wp_r <= (q_wp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : q_wp_r + 1'b1;
      end
      if (pop) begin
        q_rp_r <= (q_rp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : q_rp_r + 1'b1;
      end
      if (push && !pop) begin
        q_cnt_r <= q_cnt_r + 1'b1;
      end else if (pop && !push) begin
        q_cnt_r <= q_cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/vts_back.sv =====
// back end: grid memory, neighbour sequencer, weight and sample multiply, accumulate
// depends on vts_pkg; fed by vts_front
module vts_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  vts_pkg::qent_t                      q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vts_pkg::OUT_BITS-1:0] out_sampled_value,
  output vts_pkg::bk_stat_t                   stat
);
  import vts_pkg::*;

  localparam logic [ACC_W-1:0] HALF_ONE = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [ACC_W-1:0] HALF_TWO = ACC_W'(1) << (2 * FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] OUT_MAX = (ACC_W'(1) <<< (OUT_BITS - 1)) - 1;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -(ACC_W'(1) <<< (OUT_BITS - 1));

  logic [SAMPLE_BITS-1:0] grid_mem [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [ADDR_W-1:0]      mem_addr;
  logic [ADDR_W-1:0]      rd_addr;

  qent_t      cur_r;
  logic       issuing_r;
  logic [2:0] cnt_r;
  logic       pipe_busy;
  logic       out_free;
  logic       do_write;
  logic       do_start;

  axis_pos_t        sel_x;
  axis_pos_t        sel_y;
  axis_pos_t        sel_z;
  logic [WGT_W-1:0] wsel_x;
  logic [WGT_W-1:0] wsel_y;
  logic [WGT_W-1:0] wsel_z;

  logic             v1_r, last1_r, zero1_r;
  logic [WXY_W-1:0] wxy1_r;
  logic [WGT_W-1:0] wz1_r;
  logic             v2_r, last2_r, zero2_r;
  logic [W_W-1:0]   w2_r;
  logic [SAMPLE_BITS-1:0] d2_r;
  logic             v3_r, last3_r;
  logic signed [ACC_W-1:0] p3_r;
  logic signed [ACC_W-1:0] acc_r;
  logic             fin_r;

  logic                    neg;
  logic [ACC_W-1:0]        mag;
  logic [ACC_W-1:0]        rnd;
  logic signed [ACC_W-1:0] sres;
  logic                    out_valid_r;
  logic [OUT_BITS-1:0]     out_data_r;

  // dispatch from the queue
  assign pipe_busy = issuing_r || v1_r || v2_r || v3_r || fin_r;
  assign out_free  = !out_valid_r || out_ready;
  assign do_write  = q_valid && !q_head.is_sample && !issuing_r;
  assign do_start  = q_valid && q_head.is_sample && !pipe_busy && out_free;
  assign q_pop     = do_write || do_start;

  // neighbour select for the current step
  always_comb begin
    sel_x    = cur_r.px[cnt_r[0]];
    sel_y    = cur_r.py[cnt_r[1]];
    sel_z    = cur_r.pz[cnt_r[2]];
    wsel_x   = cur_r.wx[cnt_r[0]];
    wsel_y   = cur_r.wy[cnt_r[1]];
    wsel_z   = cur_r.wz[cnt_r[2]];
    rd_addr  = {sel_z.idx, sel_y.idx, sel_x.idx};
    mem_addr = do_write ? q_head.addr : rd_addr;
  end

  // single-port grid memory
  always_ff @(posedge clk) begin
    if (do_write) begin
      grid_mem[mem_addr] <= q_head.data;
    end else begin
      rd_q <= grid_mem[mem_addr];
    end
  end

  // neighbour sequencer
  always_ff @(posedge clk) begin
    if (do_start) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      cnt_r     <= '0;
    end else if (do_start) begin
      issuing_r <= 1'b1;
      cnt_r     <= '0;
    end else if (issuing_r) begin
      if (cnt_r == cur_r.last) begin
        issuing_r <= 1'b0;
      end
      cnt_r <= cnt_r + 3'd1;
    end
  end

  // pipeline control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      v1_r  <= issuing_r;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      fin_r <= v3_r && last3_r;
    end
  end

  // stage 1: xy weight, memory read in flight
  always_ff @(posedge clk) begin
    last1_r <= (cnt_r == cur_r.last);
    zero1_r <= sel_x.zero || sel_y.zero || sel_z.zero;
    wxy1_r  <= WXY_W'(wsel_x) * WXY_W'(wsel_y);
    wz1_r   <= wsel_z;
  end

  // stage 2: full weight, sample captured
  always_ff @(posedge clk) begin
    last2_r <= last1_r;
    zero2_r <= zero1_r;
    w2_r    <= W_W'(wxy1_r) * W_W'(wz1_r);
    d2_r    <= rd_q;
  end

  // stage 3: weighted sample, zero-weight and border cells skipped
  always_ff @(posedge clk) begin
    last3_r <= last2_r;
    if (zero2_r || (w2_r == '0)) begin
      p3_r <= '0;
    end else begin
      p3_r <= ACC_W'($signed(d2_r)) * ACC_W'($signed({1'b0, w2_r}));
    end
  end

  // stage 4: exact sum
  always_ff @(posedge clk) begin
    if (do_start) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= acc_r + p3_r;
    end
  end

  // round half away from zero (no rounding for nearest), then saturate
  always_comb begin
    neg = acc_r[ACC_W-1];
    mag = neg ? ACC_W'(-acc_r) : acc_r;
    case (cur_r.sh)
      SH_NONE: rnd = mag;
      SH_ONE:  rnd = (mag + HALF_ONE) >> FRAC_BITS;
      SH_TWO:  rnd = (mag + HALF_TWO) >> (2 * FRAC_BITS);
      default: rnd = mag;
    endcase
    sres = neg ? -$signed(rnd) : $signed(rnd);
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin_r) begin
      if (sres > OUT_MAX) begin
        out_data_r <= OUT_MAX[OUT_BITS-1:0];
      end else if (sres < OUT_MIN) begin
        out_data_r <= OUT_MIN[OUT_BITS-1:0];
      end else begin
        out_data_r <= sres[OUT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sampled_value = $signed(out_data_r);
  assign stat.busy         = pipe_busy;
  assign stat.fin          = fin_r;

endmodule

// ===== tb/volume_trilinear_sampler_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for volume_trilinear_sampler_unit: grid writes, nearest and
// blended samples, clamp and zero border, 2D and 3D; every result checked against a predictor
// depends on vts_pkg and the rtl of the block
module volume_trilinear_sampler_unit_tb;
  import vts_pkg::*;

  localparam logic OP_WRITE      = 1'b0;
  localparam int   ONE_POS       = 1 << FRAC_BITS;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   HOLD_LEN      = 300;
  localparam int   DRAIN_LIMIT   = 200000;
  localparam int   IDLE_PCT      = 52;
  localparam int   BOTH_PCT      = 32;

  typedef struct {
    logic                          op;
    logic [ADDR_W-1:0]             addr;
    logic signed [SAMPLE_BITS-1:0] value;
    logic signed [COORD_BITS-1:0]  cx;
    logic signed [COORD_BITS-1:0]  cy;
    logic signed [COORD_BITS-1:0]  cz;
  } grid_item_t;

  // block ports
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_op = 1'b0;
  logic [ADDR_W-1:0]             in_cell_address = '0;
  logic signed [SAMPLE_BITS-1:0] in_cell_value = '0;
  logic signed [COORD_BITS-1:0]  in_coord_x = '0;
  logic signed [COORD_BITS-1:0]  in_coord_y = '0;
  logic signed [COORD_BITS-1:0]  in_coord_z = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [OUT_BITS-1:0]    out_sampled_value;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [PADDR_W-1:0]            paddr = '0;
  logic [PDATA_W-1:0]            pwdata = '0;
  logic [PDATA_W-1:0]            prdata;
  logic                          pready;

  // configuration as the block holds it
  bit       cur_linear = 1'b1;
  bit       cur_zero_border = 1'b0;
  bit       cur_three = 1'b1;
  bit [6:0] cur_ext_x = 7'd64;
  bit [6:0] cur_ext_y = 7'd64;
  bit [6:0] cur_ext_z = 7'd64;

  // predictor grid, stimulus bookkeeping and expected results
  shortint                    grid_mem [STORE_DEPTH];
  bit                         cell_filled [STORE_DEPTH];
  grid_item_t                 pend_items [$];
  logic signed [OUT_BITS-1:0] expected_samples [$];
  logic signed [OUT_BITS-1:0] want_value;
  grid_item_t                 drive_item;
  logic                       in_fire = 1'b0;
  int                         send_idle_pct = 0;
  int                         recv_stall_pct = 0;
  int                         fail_count = 0;
  bit                         hold_go = 1'b0;
  bit                         hold_seen = 1'b0;
  int                         hold_left = 0;

  volume_trilinear_sampler_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_cell_address(in_cell_address), .in_cell_value(in_cell_value),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_sampled_value(out_sampled_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // extent register as used: 0 acts as 1, above the side acts as the side
  function automatic int eff_side(input bit [6:0] e);
    if (e == 0) return 1;
    if (e > MAX_SIDE) return MAX_SIDE;
    return int'(e);
  endfunction

  function automatic longint round_away(input longint c);
    longint half;
    half = ONE_POS / 2;
    if (c >= 0) return (c + half) >>> FRAC_BITS;
    return -(((-c) + half) >>> FRAC_BITS);
  endfunction

  // clamp one index, or report it as a zero border cell
  function automatic bit fit_axis(inout longint i, input int side);
    if (i < 0 || i >= side) begin
      if (cur_zero_border) return 1'b0;
      i = (i < 0) ? 0 : side - 1;
    end
    return 1'b1;
  endfunction

  function automatic bit locate_cell(input longint ix, input longint iy, input longint iz,
                                     output int addr);
    addr = 0;
    if (!fit_axis(ix, eff_side(cur_ext_x))) return 1'b0;
    if (!fit_axis(iy, eff_side(cur_ext_y))) return 1'b0;
    if (!cur_three) iz = 0;
    else if (!fit_axis(iz, eff_side(cur_ext_z))) return 1'b0;
    addr = int'((iz * MAX_SIDE + iy) * MAX_SIDE + ix);
    return 1'b1;
  endfunction

  // cells touched by one sample, with their weights and the final rounding shift
  function automatic int neighbour_cells(input logic signed [COORD_BITS-1:0] qx,
                                         input logic signed [COORD_BITS-1:0] qy,
                                         input logic signed [COORD_BITS-1:0] qz,
                                         output int cell_addr [8], output bit cell_real [8],
                                         output longint cell_wt [8], output int rnd_shift);
    longint cx, cy, cz, x0, y0, z0, fx, fy, fz, wx, wy, wz;
    int     cnt, n, dx, dy, dz;
    cx = qx;
    cy = qy;
    cz = cur_three ? longint'(qz) : 0;
    for (n = 0; n < 8; n++) begin
      cell_addr[n] = 0;
      cell_real[n] = 1'b0;
      cell_wt[n] = 0;
    end
    if (!cur_linear) begin
      cnt = 1;
      rnd_shift = 0;
      cell_wt[0] = ONE_POS;
      cell_real[0] = locate_cell(round_away(cx), round_away(cy), round_away(cz), cell_addr[0]);
    end else begin
      x0 = cx >>> FRAC_BITS;
      y0 = cy >>> FRAC_BITS;
      z0 = cz >>> FRAC_BITS;
      fx = cx - x0 * ONE_POS;
      fy = cy - y0 * ONE_POS;
      fz = cz - z0 * ONE_POS;
      cnt = cur_three ? 8 : 4;
      rnd_shift = cur_three ? 2 * FRAC_BITS : FRAC_BITS;
      for (n = 0; n < cnt; n++) begin
        dx = n & 1;
        dy = (n >> 1) & 1;
        dz = (n >> 2) & 1;
        wx = dx ? fx : ONE_POS - fx;
        wy = dy ? fy : ONE_POS - fy;
        wz = cur_three ? (dz ? fz : ONE_POS - fz) : 1;
        cell_wt[n] = wx * wy * wz;
        cell_real[n] = locate_cell(x0 + dx, y0 + dy, z0 + dz, cell_addr[n]);
      end
    end
    return cnt;
  endfunction

  // exact weighted sum, at most one rounding half away from zero, then saturation
  function automatic logic signed [OUT_BITS-1:0] predict_sample(
    input logic signed [COORD_BITS-1:0] qx, input logic signed [COORD_BITS-1:0] qy,
    input logic signed [COORD_BITS-1:0] qz);
    int     cell_addr [8];
    bit     cell_real [8];
    longint cell_wt [8];
    int     cnt, rnd_shift, n;
    longint total, mag, res, top, bottom;
    cnt = neighbour_cells(qx, qy, qz, cell_addr, cell_real, cell_wt, rnd_shift);
    total = 0;
    for (n = 0; n < cnt; n++)
      if (cell_real[n]) total += longint'(grid_mem[cell_addr[n]]) * cell_wt[n];
    if (rnd_shift == 0) begin
      res = total;
    end else begin
      mag = (total < 0) ? -total : total;
      mag = (mag + (longint'(1) << (rnd_shift - 1))) >>> rnd_shift;
      res = (total < 0) ? -mag : mag;
    end
    top = (longint'(1) << (OUT_BITS - 1)) - 1;
    bottom = -(longint'(1) << (OUT_BITS - 1));
    if (res > top) res = top;
    if (res < bottom) res = bottom;
    return OUT_BITS'(res);
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // coordinates mostly around the grid and its edges, with integer and half positions
  function automatic int rand_coord(input int side);
    int c;
    case ($urandom_range(0, 9))
      0: c = int'($urandom_range(0, 1048575)) - 524288;
      1: c = (int'($urandom_range(0, side + 1)) - 1) * ONE_POS;
      2: begin
        c = int'($urandom_range(0, side)) * ONE_POS + ONE_POS / 2;
        if ($urandom_range(0, 1)) c = -c;
      end
      3, 4: c = int'($urandom_range(0, 5 * ONE_POS)) + (side - 3) * ONE_POS;
      default: c = int'($urandom_range(0, ((side < 6 ? side : 6) + 2) * ONE_POS)) - 2 * ONE_POS;
    endcase
    return c;
  endfunction

  function automatic int box_cell();
    int ix, iy, iz;
    ix = $urandom_range(0, eff_side(cur_ext_x) - 1);
    iy = $urandom_range(0, eff_side(cur_ext_y) - 1);
    iz = cur_three ? int'($urandom_range(0, eff_side(cur_ext_z) - 1)) : 0;
    return (iz * MAX_SIDE + iy) * MAX_SIDE + ix;
  endfunction

  // unused fields of an item still carry random bits
  function automatic grid_item_t random_item();
    grid_item_t it;
    it.op = OP_SAMPLE;
    it.addr = ADDR_W'($urandom);
    it.value = SAMPLE_BITS'($urandom);
    it.cx = COORD_BITS'($urandom);
    it.cy = COORD_BITS'($urandom);
    it.cz = COORD_BITS'($urandom);
    return it;
  endfunction

  function automatic void push_write(input int addr, input int value);
    grid_item_t it;
    it = random_item();
    it.op = OP_WRITE;
    it.addr = ADDR_W'(addr);
    it.value = SAMPLE_BITS'(value);
    cell_filled[it.addr] = 1'b1;
    pend_items.push_back(it);
  endfunction

  // a sample is preceded by writes to any cell it reads that holds nothing yet
  function automatic int push_sample(input int x, input int y, input int z);
    grid_item_t it;
    int         cell_addr [8];
    bit         cell_real [8];
    longint     cell_wt [8];
    int         cnt, rnd_shift, n, made;
    it = random_item();
    it.op = OP_SAMPLE;
    it.cx = COORD_BITS'(x);
    it.cy = COORD_BITS'(y);
    it.cz = COORD_BITS'(z);
    made = 1;
    cnt = neighbour_cells(it.cx, it.cy, it.cz, cell_addr, cell_real, cell_wt, rnd_shift);
    for (n = 0; n < cnt; n++) begin
      if (cell_real[n] && !cell_filled[cell_addr[n]]) begin
        push_write(cell_addr[n], rand_sample());
        made++;
      end
    end
    pend_items.push_back(it);
    return made;
  endfunction

  function automatic void fill_random(input int budget);
    int made;
    int z;
    made = 0;
    while (made < budget) begin
      if ($urandom_range(0, 99) < 25) begin
        push_write($urandom_range(0, 1) ? int'($urandom_range(0, STORE_DEPTH - 1)) : box_cell(),
                   rand_sample());
        made++;
      end else begin
        z = cur_three ? rand_coord(eff_side(cur_ext_z)) : int'($urandom_range(0, 1048575));
        made += push_sample(rand_coord(eff_side(cur_ext_x)), rand_coord(eff_side(cur_ext_y)), z);
      end
    end
  endfunction

  // wait until no item is pending or in flight, then let the pipeline settle
  task automatic wait_idle(input int settle);
    int guard;
    guard = 0;
    while ((pend_items.size() != 0 || in_valid || expected_samples.size() != 0)
           && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) begin
      $display("%0t: %0d sample results never arrived", $time, expected_samples.size());
      fail_count++;
    end
    repeat (settle) @(posedge clk);
  endtask

  // register write: setup cycle, then access cycle
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LINEAR: cur_linear = val[0];
      REG_ZB:     cur_zero_border = val[0];
      REG_THREE:  cur_three = val[0];
      REG_EXT_X:  cur_ext_x = val[6:0];
      REG_EXT_Y:  cur_ext_y = val[6:0];
      REG_EXT_Z:  cur_ext_z = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input bit lin, input bit zb, input bit three, input bit [6:0] ex,
                            input bit [6:0] ey, input bit [6:0] ez, input int send_pct,
                            input int recv_pct);
    wait_idle(SETTLE_CYCLES);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    cfg_write(REG_LINEAR, PDATA_W'(lin));
    cfg_write(REG_ZB, PDATA_W'(zb));
    cfg_write(REG_THREE, PDATA_W'(three));
    cfg_write(REG_EXT_X, PDATA_W'(ex));
    cfg_write(REG_EXT_Y, PDATA_W'(ey));
    cfg_write(REG_EXT_Z, PDATA_W'(ez));
  endtask

  // item driver, fed from the pending queue
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pend_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_item = pend_items.pop_front();
        in_op <= drive_item.op;
        in_cell_address <= drive_item.addr;
        in_cell_value <= drive_item.value;
        in_coord_x <= drive_item.cx;
        in_coord_y <= drive_item.cy;
        in_coord_z <= drive_item.cz;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side ready, with random stalls and a single long hold-off
  always @(negedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // accepted items update the predictor, accepted results are checked
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        if (in_op == OP_SAMPLE)
          expected_samples.push_back(predict_sample(in_coord_x, in_coord_y, in_coord_z));
        else
          grid_mem[in_cell_address] = in_cell_value;
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d", $time, out_sampled_value);
          fail_count++;
        end else begin
          want_value = expected_samples.pop_front();
          if (out_sampled_value !== want_value) begin
            $display("%0t: sampled_value mismatch, expected %0d, got %0d",
                     $time, want_value, out_sampled_value);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: trilinear, clamp; extreme addresses, values and coordinates
    push_write(0, 32767);
    push_write(STORE_DEPTH - 1, -32768);
    void'(push_sample(-524288, -524288, -524288));
    void'(push_sample(524287, 524287, 524287));
    void'(push_sample(384, 576, 192));
    void'(push_sample(-128, -64, 320));
    void'(push_sample(63 * ONE_POS, 63 * ONE_POS, 63 * ONE_POS));

    // nearest, 3D: ties round away from zero on both signs
    set_config(1'b0, 1'b0, 1'b1, 7'd5, 7'd3, 7'd4, 0, 0);
    void'(push_sample(128, -128, 384));
    void'(push_sample(127, -129, 640));
    void'(push_sample(-524288, 524287, 1000));
    fill_random(150);

    // single-cell grid with zero border
    set_config(1'b1, 1'b1, 1'b1, 7'd1, 7'd1, 7'd1, IDLE_PCT, 0);
    void'(push_sample(-ONE_POS, 0, 0));
    void'(push_sample(128, 128, 128));
    void'(push_sample(524287, -524288, 0));
    fill_random(150);

    // 2D bilinear on the full side; z extent and coord_z unused
    set_config(1'b1, 1'b0, 1'b0, 7'd64, 7'd64, 7'd0, 0, IDLE_PCT);
    void'(push_sample(128, 128, 524287));
    void'(push_sample(-200, 63 * ONE_POS + 77, -524288));
    fill_random(150);

    // extent above the side acts as the side
    set_config(1'b0, 1'b1, 1'b0, 7'd127, 7'd2, 7'd9, BOTH_PCT, BOTH_PCT);
    fill_random(150);

    // zero extent acts as one; result side holds off long enough to back up the input
    set_config(1'b1, 1'b0, 1'b1, 7'd0, 7'd7, 7'd64, 0, 0);
    fill_random(150);
    hold_go = ~hold_go;

    set_config(1'b1, 1'b1, 1'b0, 7'd6, 7'd5, 7'd1, IDLE_PCT, 0);
    fill_random(150);

    set_config(1'b0, 1'b0, 1'b1, 7'd64, 7'd64, 7'd64, 0, IDLE_PCT);
    fill_random(150);

    // sender pauses halfway until every result is back
    set_config(1'b1, 1'b1, 1'b1, 7'd8, 7'd6, 7'd3, BOTH_PCT, BOTH_PCT);
    fill_random(75);
    wait_idle(0);
    fill_random(75);

    wait_idle(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/vts_pkg.sv
sv/vts_front.sv
sv/vts_back.sv
sv/volume_trilinear_sampler_unit.sv
tb/volume_trilinear_sampler_unit_tb.sv
